/* src/sbmd_pkg.sv */
// ----------------------------------------------------------------------------
// sbmd_pkg
// Shared types and constants of the subsequence best-match distance unit.
// ----------------------------------------------------------------------------
package sbmd_pkg;

    localparam int KIND_W        = 2;
    localparam int SAMPLE_PORT_W = 16;
    localparam int POS_PORT_W    = 7;
    localparam int LEN_PORT_W    = 7;
    localparam int DIST_W        = 19;
    localparam int END_PORT_W    = 8;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int CMP_W         = 16;

    localparam int DEF_SERIES_LEN   = 128;
    localparam int DEF_MAX_SUB_LEN  = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam logic [CFG_DATA_W-1:0] MIN_LENGTH_RST = 7'd5;
    localparam logic [CFG_DATA_W-1:0] MAX_LENGTH_RST = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_QUERY = 2'd0,
        KIND_APPEND     = 2'd1,
        KIND_READ       = 2'd2,
        KIND_BEGIN      = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_LENGTH = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FETCH,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

/* src/sbmd_if.sv */
// ----------------------------------------------------------------------------
// sbmd_if
// Valid/ready channels of the subsequence best-match distance unit.
// ----------------------------------------------------------------------------
interface sbmd_cmd_if import sbmd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [SAMPLE_PORT_W-1:0] sample;
    logic [POS_PORT_W-1:0]    position;
    logic [LEN_PORT_W-1:0]    length;

    modport source (output valid, kind, sample, position, length, input ready);
    modport sink   (input valid, kind, sample, position, length, output ready);
endinterface

interface sbmd_res_if import sbmd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DIST_W-1:0]     distance;
    logic [END_PORT_W-1:0] end_position;
    logic                  found;

    modport source (output valid, distance, end_position, found, input ready);
    modport sink   (input valid, distance, end_position, found, output ready);
endinterface

interface sbmd_cfg_if import sbmd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/sbmd_query_mem.sv */
// ----------------------------------------------------------------------------
// sbmd_query_mem
// Query sample store with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sbmd_query_mem import sbmd_pkg::*; #(
    parameter int DEPTH   = DEF_SERIES_LEN,
    parameter int WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int ADDR_W  = $clog2(DEF_SERIES_LEN)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sbmd_state_mem.sv */
// ----------------------------------------------------------------------------
// sbmd_state_mem
// Per-start row store of running sums, best sums and best ends.
// ----------------------------------------------------------------------------
module sbmd_state_mem import sbmd_pkg::*; #(
    parameter int DEPTH  = DEF_SERIES_LEN,
    parameter int ROW_W  = 64,
    parameter int ADDR_W = $clog2(DEF_SERIES_LEN)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rvalid_reg;

    // A row that was not written since the last clear reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* src/sbmd_isqrt.sv */
// ----------------------------------------------------------------------------
// sbmd_isqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sbmd_isqrt import sbmd_pkg::*; #(
    parameter int SUM_W  = 38,
    parameter int ROOT_W = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int RW = 2 * ROOT_W;

    logic [RW-1:0] x_reg, x_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW-1:0] trial;

    always_comb
    begin
        trial     = root_reg + bit_reg;
        x_next    = x_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = RW'(radicand);
            root_next = '0;
            bit_next  = RW'(1) << (RW - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next    = x_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = ROOT_W'(root_reg);

endmodule

/* src/subsequence_best_match_distance_unit.sv */
// ----------------------------------------------------------------------------
// subsequence_best_match_distance_unit
// All-length subsequence best-match Euclidean distance against a target.
// ----------------------------------------------------------------------------
// The cmd channel takes one word per item: load a query sample, append a
// target sample, read a result, or begin a new target. Only a read produces
// a word on the res channel; cfg writes min_length and max_length and is
// always ready.
// An append, while fewer than SERIES_LEN target samples are held, sweeps
// the per-start row memory once, one start position per cycle with all
// lengths side by side in one wide row. The next word is taken only after
// all SERIES_LEN rows are read, the pipeline has written the last row back
// and the sequencer is back in idle. A read fetches its row, runs the
// square-root unit that retires two radicand bits per cycle and loads the
// output register before the next word is taken. Loads and begins leave
// the sequencer idle; begin clears every row's valid bit at once.
// After reset the rows read as empty, the target count is zero and the
// registers hold their reset values; the query store holds nothing useful
// until it is loaded. The result sits in an output register: while the
// receiver stalls the block goes on taking non-read words, and a later
// read waits at its end until the held result has been taken.
// ----------------------------------------------------------------------------
module subsequence_best_match_distance_unit import sbmd_pkg::*; #(
    parameter int SERIES_LEN   = DEF_SERIES_LEN,
    parameter int MAX_SUB_LEN  = DEF_MAX_SUB_LEN,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    sbmd_cmd_if.sink    cmd,
    sbmd_res_if.source  res,
    sbmd_cfg_if.sink    cfg
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int ADDR_W  = $clog2(SERIES_LEN);
    localparam int CNT_W   = $clog2(SERIES_LEN + 1);
    localparam int LANE_W  = (MAX_SUB_LEN > 1) ? $clog2(MAX_SUB_LEN) : 1;
    localparam int IX_W    = (CNT_W > LANE_W + 1) ? CNT_W : LANE_W + 1;
    localparam int SUM_W   = 2 * SW + $clog2(MAX_SUB_LEN);
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int ROW_W   = MAX_SUB_LEN * (2 * SUM_W + CNT_W);

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] min_len_reg, max_len_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     s_reg;
    logic [SW-1:0]         t_reg;
    logic                  v1_reg, v2_reg;
    logic [ADDR_W-1:0]     s1_reg, s2_reg;
    logic [LANE_W-1:0]     lane_reg;
    logic                  pair_ok_reg;
    logic [CNT_W-1:0]      hold_end_reg;
    logic                  hold_found_reg;
    logic                  out_valid_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic [END_PORT_W-1:0] out_end_reg;
    logic                  out_found_reg;

    logic cmd_ready, cmd_fire, issue, rd_issue, sqrt_start, out_load;
    kind_t kind;
    logic  append_ok, pair_ok, query_we;

    logic [CMP_W-1:0] pos_x, len_x;

    logic [SW-1:0]    q_rdata;
    logic [ROW_W-1:0] st_rdata, row_reg, st_wdata;
    logic [ADDR_W-1:0] st_raddr;

    logic [MAX_SUB_LEN-1:0][SW-1:0]     window_reg, window_next;
    logic [MAX_SUB_LEN-1:0][2*SW-1:0]   sq_next, sq_reg;
    logic [MAX_SUB_LEN-1:0][SUM_W-1:0]  row_run, row_best, rd_run, rd_best;
    logic [MAX_SUB_LEN-1:0][CNT_W-1:0]  row_end, rd_end;
    logic [MAX_SUB_LEN-1:0][SUM_W-1:0]  wr_run, wr_best;
    logic [MAX_SUB_LEN-1:0][CNT_W-1:0]  wr_end;

    logic [SUM_W-1:0]  sel_best;
    logic [CNT_W-1:0]  sel_end;
    logic              hit;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [IX_W-1:0]   lane_limit;

    assign kind     = kind_t'(cmd.kind);
    assign cmd_fire = cmd.valid && cmd_ready;
    assign pos_x    = CMP_W'(cmd.position);
    assign len_x    = CMP_W'(cmd.length);

    assign append_ok = count_reg < CNT_W'(SERIES_LEN);
    assign query_we  = cmd_fire && (kind == KIND_LOAD_QUERY) &&
                       (pos_x < CMP_W'(SERIES_LEN));

    // A read pair can be found only when it lies within the SERIES_LEN query
    // samples, its length is 1 to MAX_SUB_LEN and lies in the configured window.
    assign pair_ok = (len_x >= CMP_W'(1)) && (len_x <= CMP_W'(MAX_SUB_LEN)) &&
                     (pos_x + len_x <= CMP_W'(SERIES_LEN)) &&
                     (len_x >= CMP_W'(min_len_reg)) && (len_x <= CMP_W'(max_len_reg));

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LENGTH_RST;
            max_len_reg <= MAX_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_MIN_LENGTH: min_len_reg <= cfg.data;
                REG_MAX_LENGTH: max_len_reg <= cfg.data;
                default:        min_len_reg <= min_len_reg;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (kind == KIND_APPEND) && append_ok)
                begin
                    state_next = ST_SWEEP;
                end
                else if (cmd_fire && (kind == KIND_READ))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_SWEEP:
            begin
                if (s_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready  = 1'b0;
        issue      = 1'b0;
        rd_issue   = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                rd_issue  = cmd.valid && (kind == KIND_READ);
            end
            ST_SWEEP: issue = 1'b1;
            ST_FETCH: sqrt_start = 1'b1;
            ST_OUT:   out_load = !out_valid_reg || res.ready;
            default:  cmd_ready = 1'b0;
        endcase
    end

    assign cmd.ready = cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (cmd_fire && (kind == KIND_BEGIN))
            begin
                count_reg <= '0;
            end
            else if (cmd_fire && (kind == KIND_APPEND) && append_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s_reg;
        s2_reg <= s1_reg;
        if (cmd_fire && (kind == KIND_APPEND))
        begin
            s_reg <= ADDR_W'(SERIES_LEN - 1);
            t_reg <= cmd.sample[SW-1:0];
        end
        else if (issue)
        begin
            s_reg <= s_reg - ADDR_W'(1);
        end
        if (cmd_fire && (kind == KIND_READ))
        begin
            lane_reg    <= LANE_W'(len_x - CMP_W'(1));
            pair_ok_reg <= pair_ok;
        end
    end

    // ---------------- memories ----------------
    assign st_raddr = rd_issue ? ADDR_W'(cmd.position) : s_reg;

    sbmd_query_mem #(
        .DEPTH  (SERIES_LEN),
        .WIDTH  (SW),
        .ADDR_W (ADDR_W)
    ) u_query_mem (
        .clk   (clk),
        .we    (query_we),
        .waddr (ADDR_W'(cmd.position)),
        .wdata (cmd.sample[SW-1:0]),
        .re    (issue),
        .raddr (s_reg),
        .rdata (q_rdata)
    );

    sbmd_state_mem #(
        .DEPTH  (SERIES_LEN),
        .ROW_W  (ROW_W),
        .ADDR_W (ADDR_W)
    ) u_state_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cmd_fire && (kind == KIND_BEGIN)),
        .we    (v2_reg),
        .waddr (s2_reg),
        .wdata (st_wdata),
        .re    (issue || rd_issue),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign {rd_end, rd_best, rd_run}    = st_rdata;
    assign {row_end, row_best, row_run} = row_reg;

    // ---------------- lane datapath ----------------
    // Stage one shifts the query window so that lane l holds the query
    // sample at start + l, and squares each lane's difference to the new
    // target sample. Stage two extends the shorter running sum of the same
    // row by one square and updates the best sum of every live lane.
    assign lane_limit = IX_W'(SERIES_LEN) - IX_W'(s2_reg);

    for (genvar l = 0; l < MAX_SUB_LEN; l++)
    begin : g_lane
        logic signed [SW:0] diff;
        logic [SW:0]        mag;
        logic [SUM_W-1:0]   sum;
        logic               live;

        if (l == 0)
        begin : g_head
            assign window_next[l] = q_rdata;
            assign sum            = SUM_W'(sq_reg[l]);
        end
        else
        begin : g_tail
            assign window_next[l] = window_reg[l-1];
            assign sum            = row_run[l-1] + SUM_W'(sq_reg[l]);
        end

        assign diff = $signed({window_next[l][SW-1], window_next[l]}) -
                      $signed({t_reg[SW-1], t_reg});
        assign mag  = diff[SW] ? (SW + 1)'(-diff) : (SW + 1)'(diff);
        assign sq_next[l] = (2 * SW)'(mag[SW-1:0]) * (2 * SW)'(mag[SW-1:0]);

        assign live = (IX_W'(l) < lane_limit) && (IX_W'(l) < IX_W'(count_reg));

        always_comb
        begin
            wr_run[l]  = row_run[l];
            wr_best[l] = row_best[l];
            wr_end[l]  = row_end[l];
            if (live)
            begin
                wr_run[l] = sum;
                if ((row_end[l] == '0) || (sum < row_best[l]))
                begin
                    wr_best[l] = sum;
                    wr_end[l]  = count_reg;
                end
            end
        end
    end

    assign st_wdata = {wr_end, wr_best, wr_run};

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            window_reg <= window_next;
            sq_reg     <= sq_next;
            row_reg    <= st_rdata;
        end
    end

    // ---------------- read path ----------------
    assign sel_best = rd_best[lane_reg];
    assign sel_end  = rd_end[lane_reg];
    assign hit      = pair_ok_reg && (sel_end != '0);

    always_ff @(posedge clk)
    begin
        if (sqrt_start)
        begin
            hold_end_reg   <= hit ? sel_end : '0;
            hold_found_reg <= hit;
        end
    end

    sbmd_isqrt #(
        .SUM_W  (SUM_W),
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (hit ? sel_best : '0),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dist_reg  <= DIST_W'(sqrt_root);
            out_end_reg   <= END_PORT_W'(hold_end_reg);
            out_found_reg <= hold_found_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.distance     = out_dist_reg;
    assign res.end_position = out_end_reg;
    assign res.found        = out_found_reg;

endmodule
